@@ src/mep_pkg.sv @@
// Shared types, constants and helpers for the escape-time pixel block.
// Used by the stream interfaces and by the top level; depends on nothing.
package mep_pkg;

  localparam int DEF_COORD_WIDTH   = 24;
  localparam int DEF_FRACTION_BITS = 20;

  // Iterate z holds a signed 48-bit value whose magnitude stays below 2^47.
  localparam int Z_WIDTH    = 48;
  localparam int MAG_WIDTH  = Z_WIDTH - 1;
  localparam int PROD_WIDTH = 2 * MAG_WIDTH;
  localparam int SUM_WIDTH  = Z_WIDTH + 2;

  // The magnitudes are split into a low and a high part for the multiplier.
  localparam int LO_WIDTH  = 24;
  localparam int PP_WIDTH  = 2 * LO_WIDTH;
  localparam int NUM_PARTS = 4;

  localparam logic [MAG_WIDTH-1:0] MAG_MAX = '1;

  localparam int ITER_WIDTH      = 8;
  localparam int THRESH_WIDTH    = 16;
  localparam int COLOR_WIDTH     = 8;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH  = THRESH_WIDTH;

  localparam logic [ITER_WIDTH-1:0]   RESET_MAX_ITERATIONS   = 8'd150;
  localparam logic [THRESH_WIDTH-1:0] RESET_ESCAPE_THRESHOLD = 16'd10000;

  localparam logic [3:0] GAIN_RED   = 4'd5;
  localparam logic [3:0] GAIN_GREEN = 4'd3;
  localparam logic [3:0] GAIN_BLUE  = 4'd2;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_MAX_ITERATIONS,
    REG_ESCAPE_THRESHOLD
  } cfg_reg_t;

  // Scales a step count by a small gain and clips it to full brightness.
  function automatic logic [COLOR_WIDTH-1:0] color_channel(
    input logic [ITER_WIDTH-1:0] steps,
    input logic [3:0]            gain
  );
    logic [ITER_WIDTH+3:0] scaled;
    scaled = (ITER_WIDTH + 4)'(steps) * (ITER_WIDTH + 4)'(gain);
    if (scaled > (ITER_WIDTH + 4)'({COLOR_WIDTH{1'b1}})) begin
      return '1;
    end
    return scaled[COLOR_WIDTH-1:0];
  endfunction

endpackage

@@ src/mep_point_if.sv @@
// Stream interface that carries one point c into the pixel block.
// Depends on mep_pkg for the default coordinate width.
interface mep_point_if
  import mep_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] c_real;
  logic signed [COORD_WIDTH-1:0] c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink (input valid, input c_real, input c_imag, output ready);
endinterface

@@ src/mep_color_if.sv @@
// Stream interface that carries one pixel color result out of the block.
// Depends on mep_pkg for the field widths.
interface mep_color_if
  import mep_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [COLOR_WIDTH-1:0] red;
  logic [COLOR_WIDTH-1:0] green;
  logic [COLOR_WIDTH-1:0] blue;
  logic [ITER_WIDTH-1:0]  steps_taken;
  logic                   escaped;

  modport source (output valid, output red, output green, output blue,
                  output steps_taken, output escaped, input ready);
  modport sink (input valid, input red, input green, input blue,
                input steps_taken, input escaped, output ready);
endinterface

@@ src/mandelbrot_escape_pixel.sv @@
// Top level of the escape-time pixel block: sequencer and shared multiplier.
// Depends on mep_pkg, mep_point_if and mep_color_if.
//
// The block takes one point c, iterates z = z*z + c from zero with one shared
// 24x24 multiplier, and returns one color per point. Each product of two
// 47-bit magnitudes takes four multiplier passes plus load and normalize;
// an iteration step needs three products plus the escape test, the update
// and the limit check. A point that escapes finishes at its escape test; a
// point that stays inside finishes at the limit check after max_iterations
// steps. A new point is taken only while the sequencer is idle, and the
// finished color sits in an output register, so the next point may be taken
// before the color is collected.
module mandelbrot_escape_pixel
  import mep_pkg::*;
#(
  parameter int COORD_WIDTH   = DEF_COORD_WIDTH,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  mep_point_if.sink                  point,
  mep_color_if.source                color,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOAD,
    ST_MUL,
    ST_NORM,
    ST_TEST,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_RR,
    OP_II,
    OP_RI
  } op_t;

  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = SUM_WIDTH'(MAG_MAX);
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = -SUM_MAX;
  localparam int SAT_LSB = FRACTION_BITS + MAG_WIDTH;

  function automatic logic [MAG_WIDTH-1:0] magnitude(input logic signed [Z_WIDTH-1:0] v);
    logic signed [Z_WIDTH-1:0] pos;
    pos = v[Z_WIDTH-1] ? -v : v;
    return pos[MAG_WIDTH-1:0];
  endfunction

  logic [ITER_WIDTH-1:0]   max_iterations;
  logic [THRESH_WIDTH-1:0] escape_threshold;

  state_t                        state;
  op_t                           op;
  logic signed [COORD_WIDTH-1:0] c_real_r;
  logic signed [COORD_WIDTH-1:0] c_imag_r;
  logic signed [Z_WIDTH-1:0]     zr;
  logic signed [Z_WIDTH-1:0]     zi;
  logic [MAG_WIDTH-1:0]          rr;
  logic [MAG_WIDTH-1:0]          ii;
  logic signed [Z_WIDTH-1:0]     ri;
  logic [ITER_WIDTH-1:0]         iter;
  logic                          hit;

  logic [MAG_WIDTH-1:0]  mag_a;
  logic [MAG_WIDTH-1:0]  mag_b;
  logic                  neg;
  logic [2:0]            part;
  logic [PP_WIDTH-1:0]   pp;
  logic [1:0]            pp_pos;
  logic [PROD_WIDTH-1:0] acc;

  logic                   out_valid;
  logic [COLOR_WIDTH-1:0] out_red;
  logic [COLOR_WIDTH-1:0] out_green;
  logic [COLOR_WIDTH-1:0] out_blue;
  logic [ITER_WIDTH-1:0]  out_steps;
  logic                   out_escaped;

  logic [LO_WIDTH-1:0]          a_chunk;
  logic [LO_WIDTH-1:0]          b_chunk;
  logic [PP_WIDTH-1:0]          mul_out;
  logic [PROD_WIDTH-1:0]        pp_aligned;
  logic [MAG_WIDTH-1:0]         prod_mag;
  logic signed [Z_WIDTH-1:0]    prod_val;
  logic [Z_WIDTH-1:0]           sq_sum;
  logic [Z_WIDTH-1:0]           limit;
  logic signed [SUM_WIDTH-1:0]  zr_sum;
  logic signed [SUM_WIDTH-1:0]  zi_sum;
  logic signed [Z_WIDTH-1:0]    zr_next;
  logic signed [Z_WIDTH-1:0]    zi_next;
  logic                         in_xfer;
  logic                         out_free;

  assign point.ready       = (state == ST_IDLE);
  assign in_xfer           = point.valid && point.ready;
  assign out_free          = !out_valid || color.ready;
  assign color.valid       = out_valid;
  assign color.red         = out_red;
  assign color.green       = out_green;
  assign color.blue        = out_blue;
  assign color.steps_taken = out_steps;
  assign color.escaped     = out_escaped;

  // Partial product k uses the high part of a when bit 1 is set, of b when bit 0 is.
  assign a_chunk = part[1] ? LO_WIDTH'(mag_a[MAG_WIDTH-1:LO_WIDTH]) : mag_a[LO_WIDTH-1:0];
  assign b_chunk = part[0] ? LO_WIDTH'(mag_b[MAG_WIDTH-1:LO_WIDTH]) : mag_b[LO_WIDTH-1:0];
  assign mul_out = a_chunk * b_chunk;

  always_comb begin
    case (pp_pos)
      2'd0:    pp_aligned = PROD_WIDTH'(pp);
      2'd1:    pp_aligned = PROD_WIDTH'(pp) << LO_WIDTH;
      default: pp_aligned = PROD_WIDTH'(pp) << (2 * LO_WIDTH);
    endcase
  end

  assign prod_mag = (|acc[PROD_WIDTH-1:SAT_LSB]) ? MAG_MAX : acc[SAT_LSB-1:FRACTION_BITS];
  assign prod_val = neg ? -$signed({1'b0, prod_mag}) : $signed({1'b0, prod_mag});

  assign sq_sum = {1'b0, rr} + {1'b0, ii};
  assign limit  = Z_WIDTH'(escape_threshold) << FRACTION_BITS;

  assign zr_sum = SUM_WIDTH'(rr) - SUM_WIDTH'(ii) + SUM_WIDTH'(c_real_r);
  assign zi_sum = (SUM_WIDTH'(ri) <<< 1) + SUM_WIDTH'(c_imag_r);

  always_comb begin
    if (zr_sum > SUM_MAX) begin
      zr_next = Z_WIDTH'(SUM_MAX);
    end else if (zr_sum < SUM_MIN) begin
      zr_next = Z_WIDTH'(SUM_MIN);
    end else begin
      zr_next = Z_WIDTH'(zr_sum);
    end
    if (zi_sum > SUM_MAX) begin
      zi_next = Z_WIDTH'(SUM_MAX);
    end else if (zi_sum < SUM_MIN) begin
      zi_next = Z_WIDTH'(SUM_MIN);
    end else begin
      zi_next = Z_WIDTH'(zi_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations   <= RESET_MAX_ITERATIONS;
      escape_threshold <= RESET_ESCAPE_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MAX_ITERATIONS:   max_iterations   <= cfg_data[ITER_WIDTH-1:0];
        REG_ESCAPE_THRESHOLD: escape_threshold <= cfg_data[THRESH_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (color.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            c_real_r <= point.c_real;
            c_imag_r <= point.c_imag;
            zr       <= '0;
            zi       <= '0;
            iter     <= '0;
            state    <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (iter == max_iterations) begin
            hit   <= 1'b0;
            state <= ST_DONE;
          end else begin
            op    <= OP_RR;
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          case (op)
            OP_RR: begin
              mag_a <= magnitude(zr);
              mag_b <= magnitude(zr);
              neg   <= 1'b0;
            end
            OP_II: begin
              mag_a <= magnitude(zi);
              mag_b <= magnitude(zi);
              neg   <= 1'b0;
            end
            default: begin
              mag_a <= magnitude(zr);
              mag_b <= magnitude(zi);
              neg   <= zr[Z_WIDTH-1] ^ zi[Z_WIDTH-1];
            end
          endcase
          acc   <= '0;
          part  <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          // The product of one pass is added to the accumulator in the next.
          if (part != 3'(NUM_PARTS)) begin
            pp     <= mul_out;
            pp_pos <= 2'(part[1]) + 2'(part[0]);
          end
          if (part != 3'd0) begin
            acc <= acc + pp_aligned;
          end
          if (part == 3'(NUM_PARTS)) begin
            state <= ST_NORM;
          end
          part <= part + 3'd1;
        end
        ST_NORM: begin
          case (op)
            OP_RR: begin
              rr    <= prod_mag;
              op    <= OP_II;
              state <= ST_LOAD;
            end
            OP_II: begin
              ii    <= prod_mag;
              state <= ST_TEST;
            end
            default: begin
              ri    <= prod_val;
              state <= ST_UPDATE;
            end
          endcase
        end
        ST_TEST: begin
          if (sq_sum >= limit) begin
            hit   <= 1'b1;
            state <= ST_DONE;
          end else begin
            op    <= OP_RI;
            state <= ST_LOAD;
          end
        end
        ST_UPDATE: begin
          zr    <= zr_next;
          zi    <= zi_next;
          iter  <= iter + 1'b1;
          state <= ST_CHECK;
        end
        ST_DONE: begin
          if (out_free) begin
            out_red     <= hit ? color_channel(iter, GAIN_RED) : '0;
            out_green   <= hit ? color_channel(iter, GAIN_GREEN) : '0;
            out_blue    <= hit ? color_channel(iter, GAIN_BLUE) : '0;
            out_steps   <= iter;
            out_escaped <= hit;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_start_check: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state == ST_CHECK)
    else $error("Accepted point did not start at the limit check.");

  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && state != ST_DONE) |-> iter <= max_iterations)
    else $error("Step count passed the iteration limit.");

  a_inside_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !hit) |-> iter == max_iterations)
    else $error("Inside point finished before the iteration limit.");

  a_z_range: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (zr != {1'b1, {MAG_WIDTH{1'b0}}} &&
                            zi != {1'b1, {MAG_WIDTH{1'b0}}}))
    else $error("Iterate left the symmetric saturation range.");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("Result appeared without a finished point.");

endmodule
